/* rtl/core/assert_macros.svh */
// assertion macros used by the cipher rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge out of reset
`define XTEA_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define XTEA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define XTEA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/xtea_pkg.sv */
// shared types and constants of the xtea cipher core
package xtea_pkg;

    localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;

    typedef enum logic {
        CMD_ENCRYPT = 1'b0,
        CMD_DECRYPT = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } t_block;

    typedef struct packed {
        t_cmd             cmd;
        t_block           blk;
        logic [3:0][31:0] key;
    } t_item;

endpackage

/* rtl/core/xtea_half_round.sv */
// one registered xtea half-round stage, sum and key index fixed per stage
module xtea_half_round
    import xtea_pkg::*;
#(
    parameter int ROUND_COUNT = 32,
    parameter int STAGE       = 0
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item
);

    localparam bit          EVEN     = (STAGE % 2) == 0;
    localparam int          ENC_MULT = STAGE / 2 + STAGE % 2;
    localparam int          DEC_MULT = ROUND_COUNT - ENC_MULT;
    localparam logic [63:0] ENC_PROD = 64'(ENC_MULT) * 64'(XTEA_DELTA);
    localparam logic [63:0] DEC_PROD = 64'(DEC_MULT) * 64'(XTEA_DELTA);
    localparam logic [31:0] ENC_SUM  = ENC_PROD[31:0];
    localparam logic [31:0] DEC_SUM  = DEC_PROD[31:0];
    localparam logic [1:0]  ENC_IDX  = EVEN ? ENC_SUM[1:0] : ENC_SUM[12:11];
    localparam logic [1:0]  DEC_IDX  = EVEN ? DEC_SUM[12:11] : DEC_SUM[1:0];

    function automatic logic [31:0] mix_word(input logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    logic        r_valid;
    t_item       r_item;
    t_item       n_item;
    logic        upd_a;
    logic        is_dec;
    logic [31:0] src_word;
    logic [31:0] dst_word;
    logic [31:0] sum_key;
    logic [31:0] f_val;
    logic [31:0] new_word;

    always_comb begin
        is_dec   = (i_item.cmd == CMD_DECRYPT);
        // encrypt updates a on even stages, decrypt on odd stages
        upd_a    = EVEN ? !is_dec : is_dec;
        src_word = upd_a ? i_item.blk.b : i_item.blk.a;
        dst_word = upd_a ? i_item.blk.a : i_item.blk.b;
        sum_key  = is_dec ? (DEC_SUM + i_item.key[DEC_IDX])
                          : (ENC_SUM + i_item.key[ENC_IDX]);
        f_val    = mix_word(src_word) ^ sum_key;
        new_word = is_dec ? (dst_word - f_val) : (dst_word + f_val);
        n_item   = i_item;
        if (upd_a) begin
            n_item.blk.a = new_word;
        end else begin
            n_item.blk.b = new_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/core/xtea_out_buf.sv */
// output register plus skid entry, decouples pipeline advance from downstream ready
`include "assert_macros.svh"

module xtea_out_buf
    import xtea_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    input  t_block i_data,
    output logic   o_en,
    output logic   o_tvalid,
    input  logic   i_tready,
    output t_block o_tdata
);

    logic   r_out_valid;
    t_block r_out_data;
    logic   r_skid_valid;
    t_block r_skid_data;
    logic   pipe_en;
    logic   out_free;

    assign pipe_en  = !r_skid_valid;
    assign out_free = !r_out_valid || i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_valid;
            end
        end else if (pipe_en && i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (pipe_en && i_valid) begin
            r_skid_data <= i_data;
        end
    end

    assign o_en     = pipe_en;
    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;

    `XTEA_ASSERT(a_skid_behind_out, !r_skid_valid || r_out_valid, "skid full with empty output")
    `XTEA_ASSERT_NEXT(a_stall_to_skid, r_out_valid && !i_tready && pipe_en && i_valid, r_skid_valid, "result dropped on stall")
    `XTEA_ASSERT_NEXT(a_skid_drain, r_skid_valid && i_tready, r_out_valid && !r_skid_valid, "skid entry not moved to output")

endmodule

/* rtl/core/xtea_block_cipher.sv */
// xtea block cipher top level: unrolled half-round pipeline with buffered output
//
//  channel   | dir | tdata (low bit up)                          | tuser
//  ----------+-----+---------------------------------------------+-------------------
//  s (item)  | in  | block_hi, block_lo, key_word0..key_word3    | command
//  m (result)| out | result_hi, result_lo                        | -
//
//  one transaction accepted per cycle while o_s_tready is high
//  a block passes through one stage per half-round, then the output register
//  i_rst_n (synchronous, active low) clears all valid bits; data registers are not reset
//  a downstream stall fills the single skid entry, which freezes the whole pipeline
//  o_s_tready comes from a register, so no combinational path runs from i_m_tready
module xtea_block_cipher
    import xtea_pkg::*;
#(
    parameter int ROUND_COUNT = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input item channel
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // [31:0] block_hi, [63:32] block_lo, [95:64] key_word0, [127:96] key_word1,
    // [159:128] key_word2, [191:160] key_word3
    input  logic [191:0]  i_s_tdata,
    // [0] command: 0 encrypt, 1 decrypt
    input  logic          i_s_tuser,
    // result channel
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // [31:0] result_hi, [63:32] result_lo
    output logic [63:0]   o_m_tdata
);

    localparam int STAGES = 2 * ROUND_COUNT;

    // stage 0 is the raw input, stage STAGES the last half-round register
    logic  stage_valid [0:STAGES];
    t_item stage_item  [0:STAGES];
    logic  pipe_en;
    t_block out_blk;

    assign stage_valid[0]        = i_s_tvalid;
    assign stage_item[0].cmd     = t_cmd'(i_s_tuser);
    assign stage_item[0].blk.a   = i_s_tdata[31:0];
    assign stage_item[0].blk.b   = i_s_tdata[63:32];
    assign stage_item[0].key[0]  = i_s_tdata[95:64];
    assign stage_item[0].key[1]  = i_s_tdata[127:96];
    assign stage_item[0].key[2]  = i_s_tdata[159:128];
    assign stage_item[0].key[3]  = i_s_tdata[191:160];

    // each stage applies one half-round with a sum constant fixed by its stage index
    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        xtea_half_round #(
            .ROUND_COUNT (ROUND_COUNT),
            .STAGE       (g)
        ) u_half_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (pipe_en),
            .i_valid (stage_valid[g]),
            .i_item  (stage_item[g]),
            .o_valid (stage_valid[g+1]),
            .o_item  (stage_item[g+1])
        );
    end

    // output register and skid entry; its enable steps every stage at once
    xtea_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid[STAGES]),
        .i_data   (stage_item[STAGES].blk),
        .o_en     (pipe_en),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (out_blk)
    );

    assign o_s_tready = pipe_en;
    assign o_m_tdata  = {out_blk.b, out_blk.a};

endmodule

/* tb/xtea_block_cipher_tb.sv */
// self-checking testbench for the xtea block cipher core: stream stimulus and scoreboard
`timescale 1ns / 100ps

// keeps the blocks still in flight and checks each result against the cipher
class xtea_result_tracker;
    int unsigned rounds;
    int unsigned failures;
    logic [63:0] pending_blocks [$];

    function new(int unsigned round_count);
        rounds   = round_count;
        failures = 0;
    endfunction

    function logic [31:0] feistel_mix(logic [31:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    // blk and the return value use the stream layout: [31:0] first word, [63:32] second
    // key holds key_word0 in its low 32 bits
    function logic [63:0] cipher_block(xtea_pkg::t_cmd cmd, logic [63:0] blk,
                                       logic [127:0] key);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] sum;
        logic [31:0] kw [4];
        a = blk[31:0];
        b = blk[63:32];
        for (int i = 0; i < 4; i++) kw[i] = key[32*i +: 32];
        if (cmd == xtea_pkg::CMD_ENCRYPT) begin
            sum = '0;
            for (int r = 0; r < rounds; r++) begin
                a   = a + (feistel_mix(b) ^ (sum + kw[sum[1:0]]));
                sum = sum + xtea_pkg::XTEA_DELTA;
                b   = b + (feistel_mix(a) ^ (sum + kw[sum[12:11]]));
            end
        end else begin
            sum = xtea_pkg::XTEA_DELTA * 32'(rounds);
            for (int r = 0; r < rounds; r++) begin
                b   = b - (feistel_mix(a) ^ (sum + kw[sum[12:11]]));
                sum = sum - xtea_pkg::XTEA_DELTA;
                a   = a - (feistel_mix(b) ^ (sum + kw[sum[1:0]]));
            end
        end
        return {b, a};
    endfunction

    function void note_item(xtea_pkg::t_cmd cmd, logic [191:0] item_data);
        pending_blocks.push_back(cipher_block(cmd, item_data[63:0], item_data[191:64]));
    endfunction

    function void check_result(logic [63:0] result_data);
        logic [63:0] want;
        if (pending_blocks.size() == 0) begin
            $error("result with no transaction outstanding: %h", result_data);
            failures++;
            return;
        end
        want = pending_blocks.pop_front();
        if (result_data[31:0] !== want[31:0]) begin
            $error("result_hi mismatch: expected %h, actual %h", want[31:0],
                   result_data[31:0]);
            failures++;
        end
        if (result_data[63:32] !== want[63:32]) begin
            $error("result_lo mismatch: expected %h, actual %h", want[63:32],
                   result_data[63:32]);
            failures++;
        end
    endfunction

    function int unsigned outstanding();
        return pending_blocks.size();
    endfunction
endclass

module xtea_block_cipher_tb;
    import xtea_pkg::*;

    localparam int CIPHER_ROUNDS  = 32;
    localparam int PIPE_LATENCY   = 2 * CIPHER_ROUNDS + 1;
    localparam int RANDOM_ITEMS   = 1550;
    localparam int LONG_HOLD      = 400;

    logic          i_clk    = 1'b0;
    logic          rst_n    = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          o_s_tready;
    logic [191:0]  s_tdata  = '0;
    logic          s_tuser  = 1'b0;
    logic          o_m_tvalid;
    logic          m_tready = 1'b0;
    logic [63:0]   o_m_tdata;

    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    int            idle_phase  = 0;
    int            items_sent  = 0;
    int            hold_left   = 0;
    bit            hold_done   = 1'b0;

    xtea_result_tracker tracker;

    xtea_block_cipher #(
        .ROUND_COUNT(CIPHER_ROUNDS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // words biased toward the edges of the range so every bit sees both values
    function automatic logic [31:0] rand_word();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 32'h1 << $urandom_range(31);
            3: return ~(32'h1 << $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    // offer one block, idling first at the current sender rate
    task automatic send_item(input t_cmd cmd, input logic [31:0] hi, input logic [31:0] lo,
                             input logic [31:0] k0, input logic [31:0] k1,
                             input logic [31:0] k2, input logic [31:0] k3);
        logic [191:0] item_data;
        item_data = {k3, k2, k1, k0, lo, hi};
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item_data;
        s_tuser  <= cmd;
        // ready is stable mid-cycle; high there means the next edge takes the transaction
        @(negedge i_clk);
        while (o_s_tready !== 1'b1) @(negedge i_clk);
        tracker.note_item(cmd, item_data);
        items_sent++;
        @(posedge i_clk);
    endtask

    // random block, or an encrypt followed by the decrypt of its ciphertext
    task automatic send_random_item();
        logic [31:0] w [6];
        logic [63:0] cipher_text;
        t_cmd        cmd;
        foreach (w[i]) w[i] = rand_word();
        cmd = t_cmd'($urandom_range(1));
        if ($urandom_range(3) == 0) begin
            cipher_text = tracker.cipher_block(CMD_ENCRYPT, {w[1], w[0]},
                                               {w[5], w[4], w[3], w[2]});
            send_item(CMD_ENCRYPT, w[0], w[1], w[2], w[3], w[4], w[5]);
            send_item(CMD_DECRYPT, cipher_text[31:0], cipher_text[63:32],
                      w[2], w[3], w[4], w[5]);
        end else begin
            send_item(cmd, w[0], w[1], w[2], w[3], w[4], w[5]);
        end
    endtask

    // result side ready: random stalls, plus one long hold-off in the second phase
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && idle_phase == 1) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // result monitor, sampled mid-cycle when the handshake signals are settled
    initial begin
        forever begin
            @(negedge i_clk);
            if (rst_n && o_m_tvalid === 1'b1 && m_tready)
                tracker.check_result(o_m_tdata);
        end
    end

    initial begin
        logic [63:0] round_trip;
        int          target;
        tracker = new(CIPHER_ROUNDS);
        repeat (5) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed blocks: zero and all-ones words, single bits, alternating patterns
        tx_idle_pct = 21;
        rx_idle_pct = 46;
        send_item(CMD_ENCRYPT, '0, '0, '0, '0, '0, '0);
        send_item(CMD_DECRYPT, '0, '0, '0, '0, '0, '0);
        send_item(CMD_ENCRYPT, '1, '1, '1, '1, '1, '1);
        send_item(CMD_DECRYPT, '1, '1, '1, '1, '1, '1);
        send_item(CMD_ENCRYPT, '0, '0, '1, '1, '1, '1);
        send_item(CMD_DECRYPT, '1, '1, '0, '0, '0, '0);
        send_item(CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                  32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_item(CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_item(CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001,
                  32'h8000_0000, 32'h0000_0001, 32'h8000_0000);
        send_item(CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000,
                  32'h0000_0001, 32'h8000_0000, 32'h0000_0001);
        // each key word alone nonzero, so every key index is exercised
        send_item(CMD_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF, 32'hFFFF_FFFF, '0, '0, '0);
        send_item(CMD_ENCRYPT, 32'h0123_4567, 32'h89AB_CDEF, '0, 32'hFFFF_FFFF, '0, '0);
        send_item(CMD_DECRYPT, 32'h0123_4567, 32'h89AB_CDEF, '0, '0, 32'hFFFF_FFFF, '0);
        send_item(CMD_DECRYPT, 32'h0123_4567, 32'h89AB_CDEF, '0, '0, '0, 32'hFFFF_FFFF);
        // round trip of a known block
        round_trip = tracker.cipher_block(CMD_ENCRYPT, {32'hFEDC_BA98, 32'h7654_3210},
                                          {32'h0C0D0E0F, 32'h08090A0B, 32'h04050607,
                                           32'h00010203});
        send_item(CMD_ENCRYPT, 32'h7654_3210, 32'hFEDC_BA98, 32'h00010203, 32'h04050607,
                  32'h08090A0B, 32'h0C0D0E0F);
        send_item(CMD_DECRYPT, round_trip[31:0], round_trip[63:32], 32'h00010203,
                  32'h04050607, 32'h08090A0B, 32'h0C0D0E0F);

        // random part in three idling phases
        target = items_sent;
        for (int p = 0; p < 3; p++) begin
            idle_phase  = p;
            tx_idle_pct = (p == 0) ? 21 : (p == 1) ? 46 : 0;
            rx_idle_pct = (p == 0) ? 46 : (p == 1) ? 21 : 0;
            target      = target + RANDOM_ITEMS / 3;
            while (items_sent < target) send_random_item();
        end
        s_tvalid <= 1'b0;

        // drain the pipeline, then allow for any stray late result
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);

        if (tracker.failures == 0 && tracker.outstanding() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
